FILE: design/vsm_pkg.sv
package vsm_pkg;

    localparam int ELEM_W   = 16;                // element field width, signed Q8.8
    localparam int OPD_W    = ELEM_W + 1;        // multiplier operand width
    localparam int PROD_W   = 2 * OPD_W;         // multiplier product width
    localparam int ACC_W    = 48;                // Q16.16 accumulators and result word
    localparam int ABS_W    = 32;                // Q8.8 absolute-difference accumulator
    localparam int ROOT_W   = 32;                // square root result width
    localparam int RAD_W    = 2 * ROOT_W;        // radicand width
    localparam int REM_W    = ROOT_W + 2;        // square root partial remainder
    localparam int DEN_W    = 2 * ROOT_W;        // cosine denominator width
    localparam int HALF_W   = ROOT_W / 2;        // partial product slice
    localparam int CNT_W    = $clog2(ROOT_W);    // step counter width
    localparam int COS_W    = 17;                // clamped cosine magnitude width
    localparam int COS_FRAC = 16;                // cosine fraction bits

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_DOT = 2'd0;
    localparam mode_t MODE_COS = 2'd1;
    localparam mode_t MODE_EUC = 2'd2;
    localparam mode_t MODE_MAN = 2'd3;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam acc_t             ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t             ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [COS_W-1:0] COS_ONE = {1'b1, {(COS_W-1){1'b0}}};

    // Sequencer step counts (last step index of each phase)
    localparam cnt_t ACC_LAST  = cnt_t'(5);
    localparam cnt_t DMUL_LAST = cnt_t'(4);
    localparam cnt_t ITER_LAST = cnt_t'(ROOT_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_SQRT,
        ST_DMUL,
        ST_DIVCHK,
        ST_DIV,
        ST_DONE
    } state_t;

    // Clamp quotient to one and apply the sign of the dot product
    function automatic acc_t cos_result(logic [ROOT_W-1:0] q, logic neg);
        logic [COS_W-1:0] mag;
        logic [ACC_W-1:0] ext;
        mag = (q > ROOT_W'(COS_ONE)) ? COS_ONE : q[COS_W-1:0];
        ext = ACC_W'(mag);
        return neg ? acc_t'(-ext) : acc_t'(ext);
    endfunction

endpackage

FILE: design/vsm_in_if.sv
interface vsm_in_if;
    import vsm_pkg::*;

    logic  valid;
    logic  ready;
    elem_t elem_a;
    elem_t elem_b;
    logic  last_elem;

    modport source (output valid, elem_a, elem_b, last_elem, input ready);
    modport sink   (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

FILE: design/vsm_out_if.sv
interface vsm_out_if;
    import vsm_pkg::*;

    logic valid;
    logic ready;
    acc_t metric_value;
    logic saturated;

    modport source (output valid, metric_value, saturated, input ready);
    modport sink   (input valid, metric_value, saturated, output ready);
endinterface

FILE: design/vector_similarity_metric_core.sv
// Vector similarity engine. Element pairs of two vectors (signed Q8.8) arrive as words on
// elems; the pair flagged last_elem closes the vector and yields one word on result, in the
// format picked by metric_mode: dot product Q16.16, cosine similarity Q.16 (65536 = 1.0,
// 0 when either norm is zero, clamped to +/-1), euclidean distance Q8.8 (floor root) or
// manhattan distance Q8.8. All accumulators saturate; saturated flags any saturation
// within the vector, and everything clears once the result word is loaded. A single
// 17x17 multiplier computes a*b, a*a, b*b and (a-b)^2 in turn, so elems.ready drops after
// each accepted pair and the next pair is taken only when that sequence ends. The last pair
// then goes straight to ST_DONE for dot or manhattan, through a 32-step bit-serial square root
// for euclidean, and for cosine through two square roots, four denominator partial products
// on the same multiplier and, if needed, a 32-step restoring division. A finished word
// sits in an output register, so the next vector may stream in while it waits; only a
// second result stalls behind an untaken one. metric_mode is written through
// cfg_wr_en/cfg_wr_data and must only change while no vector is in progress.
module vector_similarity_metric_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  vsm_pkg::mode_t cfg_wr_data,
    vsm_in_if.sink         elems,
    vsm_out_if.source      result
);
    import vsm_pkg::*;

    // Sequencer
    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    mode_t  mode_reg;

    // Latched element pair
    logic signed [OPD_W-1:0] a_reg, a_next;
    logic signed [OPD_W-1:0] b_reg, b_next;
    logic [ELEM_W-1:0]       mag_reg, mag_next;
    logic                    last_reg, last_next;

    // Shared multiplier, registered product
    logic signed [OPD_W-1:0]  mul_x, mul_y;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg;

    // Accumulators
    acc_t             dot_reg, dot_next;
    acc_t             na_acc_reg, na_acc_next;
    acc_t             nb_acc_reg, nb_acc_next;
    acc_t             sq_reg, sq_next;
    logic [ABS_W-1:0] abs_reg, abs_next;
    logic             sat_reg, sat_next;

    // Square root unit
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              phase_reg, phase_next;
    logic [ROOT_W-1:0] na_root_reg, na_root_next;
    logic [ROOT_W-1:0] nb_root_reg, nb_root_next;

    // Divider
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  div_r_reg, div_r_next;
    logic [ROOT_W-1:0] quo_reg, quo_next;

    // Result staging and output register
    acc_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    acc_t out_val_reg, out_val_next;
    logic out_sat_reg, out_sat_next;

    // Combinational helpers
    logic signed [OPD_W-1:0] in_diff;
    logic [OPD_W-1:0]        in_mag;
    acc_t                    sa_acc;
    acc_t                    sa_term;
    logic signed [ACC_W:0]   sa_sum;
    logic                    sa_ovf;
    acc_t                    sa_res;
    logic [ABS_W:0]          abs_sum;
    logic [REM_W+1:0]        sq_rem_sh;
    logic [REM_W+1:0]        sq_trial;
    logic                    sq_ge;
    logic [REM_W-1:0]        sq_rem_step;
    logic [ROOT_W-1:0]       sq_root_step;
    logic [DEN_W-1:0]        dv_r2;
    logic                    dv_ge;
    logic [DEN_W-1:0]        dv_r_step;
    logic [ROOT_W-1:0]       dv_q_step;
    logic [ACC_W-1:0]        dot_mag;
    logic                    dot_neg;
    logic [DEN_W-1:0]        pp_ext;
    logic [DEN_W-1:0]        pp_shift;
    logic                    out_free;

    //------------------------------------------------------------------
    // Shared multiplier: operand select by phase and step
    //------------------------------------------------------------------
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                case (cnt_reg)
                    cnt_t'(0):
                    begin
                        mul_x = a_reg;
                        mul_y = b_reg;
                    end
                    cnt_t'(1):
                    begin
                        mul_x = a_reg;
                        mul_y = a_reg;
                    end
                    cnt_t'(2):
                    begin
                        mul_x = b_reg;
                        mul_y = b_reg;
                    end
                    default:
                    begin
                        mul_x = $signed({1'b0, mag_reg});
                        mul_y = $signed({1'b0, mag_reg});
                    end
                endcase
            end
            ST_DMUL:
            begin
                // na * nb as four 16x16 partial products
                case (cnt_reg)
                    cnt_t'(0):
                    begin
                        mul_x = $signed({1'b0, na_root_reg[HALF_W-1:0]});
                        mul_y = $signed({1'b0, nb_root_reg[HALF_W-1:0]});
                    end
                    cnt_t'(1):
                    begin
                        mul_x = $signed({1'b0, na_root_reg[HALF_W-1:0]});
                        mul_y = $signed({1'b0, nb_root_reg[ROOT_W-1:HALF_W]});
                    end
                    cnt_t'(2):
                    begin
                        mul_x = $signed({1'b0, na_root_reg[ROOT_W-1:HALF_W]});
                        mul_y = $signed({1'b0, nb_root_reg[HALF_W-1:0]});
                    end
                    default:
                    begin
                        mul_x = $signed({1'b0, na_root_reg[ROOT_W-1:HALF_W]});
                        mul_y = $signed({1'b0, nb_root_reg[ROOT_W-1:HALF_W]});
                    end
                endcase
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    //------------------------------------------------------------------
    // Arithmetic helpers
    //------------------------------------------------------------------
    // Input pair difference magnitude (fits ELEM_W bits unsigned)
    assign in_diff = OPD_W'(elems.elem_a) - OPD_W'(elems.elem_b);
    assign in_mag  = in_diff[OPD_W-1] ? OPD_W'(-in_diff) : OPD_W'(in_diff);

    // Shared saturating 48-bit adder; step picks the accumulator
    always_comb
    begin
        case (cnt_reg)
            cnt_t'(1): sa_acc = dot_reg;
            cnt_t'(2): sa_acc = na_acc_reg;
            cnt_t'(3): sa_acc = nb_acc_reg;
            default:   sa_acc = sq_reg;
        endcase
    end

    assign sa_term = ACC_W'(prod_reg);
    assign sa_sum  = {sa_acc[ACC_W-1], sa_acc} + {sa_term[ACC_W-1], sa_term};
    assign sa_ovf  = sa_sum[ACC_W] != sa_sum[ACC_W-1];
    assign sa_res  = sa_ovf ? (sa_sum[ACC_W] ? ACC_MIN : ACC_MAX) : sa_sum[ACC_W-1:0];

    assign abs_sum = {1'b0, abs_reg} + (ABS_W+1)'(mag_reg);

    // One bit of the restoring square root
    assign sq_rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial     = (REM_W+2)'({root_reg, 2'b01});
    assign sq_ge        = sq_rem_sh >= sq_trial;
    assign sq_rem_step  = sq_ge ? REM_W'(sq_rem_sh - sq_trial) : REM_W'(sq_rem_sh);
    assign sq_root_step = {root_reg[ROOT_W-2:0], sq_ge};

    // One bit of the restoring division (remainder stays below den < 2^63)
    assign dv_r2     = {div_r_reg[DEN_W-2:0], 1'b0};
    assign dv_ge     = dv_r2 >= den_reg;
    assign dv_r_step = dv_ge ? dv_r2 - den_reg : dv_r2;
    assign dv_q_step = {quo_reg[ROOT_W-2:0], dv_ge};

    assign dot_neg = dot_reg[ACC_W-1];
    assign dot_mag = dot_neg ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);

    // Denominator partial product placement
    assign pp_ext = DEN_W'(prod_reg[2*HALF_W-1:0]);
    always_comb
    begin
        case (cnt_reg)
            cnt_t'(1): pp_shift = pp_ext;
            cnt_t'(2): pp_shift = pp_ext << HALF_W;
            cnt_t'(3): pp_shift = pp_ext << HALF_W;
            default:   pp_shift = pp_ext << ROOT_W;
        endcase
    end

    assign out_free = !out_valid_reg || result.ready;

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (elems.valid)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (cnt_reg == ACC_LAST)
                begin
                    if (!last_reg)
                        state_next = ST_IDLE;
                    else if (mode_reg == MODE_COS || mode_reg == MODE_EUC)
                        state_next = ST_SQRT;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == ITER_LAST)
                begin
                    if (mode_reg != MODE_COS)
                        state_next = ST_DONE;
                    else if (phase_reg)
                        state_next = ST_DMUL;
                end
            end
            ST_DMUL:
            begin
                if (cnt_reg == DMUL_LAST)
                    state_next = ST_DIVCHK;
            end
            ST_DIVCHK:
            begin
                if (den_reg == '0 || DEN_W'(dot_mag) >= den_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == ITER_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // Datapath and output next values
    //------------------------------------------------------------------
    always_comb
    begin
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mag_next     = mag_reg;
        last_next    = last_reg;
        dot_next     = dot_reg;
        na_acc_next  = na_acc_reg;
        nb_acc_next  = nb_acc_reg;
        sq_next      = sq_reg;
        abs_next     = abs_reg;
        sat_next     = sat_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        phase_next   = phase_reg;
        na_root_next = na_root_reg;
        nb_root_next = nb_root_reg;
        den_next     = den_reg;
        div_r_next   = div_r_reg;
        quo_next     = quo_reg;
        res_next     = res_reg;
        out_val_next = out_val_reg;
        out_sat_next = out_sat_reg;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (elems.valid)
                begin
                    a_next    = OPD_W'(elems.elem_a);
                    b_next    = OPD_W'(elems.elem_b);
                    mag_next  = in_mag[ELEM_W-1:0];
                    last_next = elems.last_elem;
                end
            end
            ST_ACCUM:
            begin
                cnt_next = cnt_reg + cnt_t'(1);
                case (cnt_reg)
                    cnt_t'(1): dot_next    = sa_res;
                    cnt_t'(2): na_acc_next = sa_res;
                    cnt_t'(3): nb_acc_next = sa_res;
                    cnt_t'(4): sq_next     = sa_res;
                    default: ;
                endcase
                if (cnt_reg >= cnt_t'(1) && cnt_reg <= cnt_t'(4) && sa_ovf)
                    sat_next = 1'b1;
                if (cnt_reg == cnt_t'(4))
                begin
                    if (abs_sum[ABS_W])
                    begin
                        abs_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                        abs_next = abs_sum[ABS_W-1:0];
                end
                if (cnt_reg == ACC_LAST)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    phase_next = 1'b0;
                    case (mode_reg)
                        MODE_DOT: res_next = dot_reg;
                        MODE_MAN: res_next = ACC_W'(abs_reg);
                        MODE_EUC: rad_next = RAD_W'($unsigned(sq_reg));
                        MODE_COS: rad_next = RAD_W'($unsigned(na_acc_reg)) << COS_FRAC;
                        default:  res_next = dot_reg;
                    endcase
                end
            end
            ST_SQRT:
            begin
                cnt_next  = cnt_reg + cnt_t'(1);
                rad_next  = rad_reg << 2;
                rem_next  = sq_rem_step;
                root_next = sq_root_step;
                if (cnt_reg == ITER_LAST)
                begin
                    cnt_next = '0;
                    if (mode_reg != MODE_COS)
                        res_next = ACC_W'(sq_root_step);
                    else if (!phase_reg)
                    begin
                        na_root_next = sq_root_step;
                        rad_next     = RAD_W'($unsigned(nb_acc_reg)) << COS_FRAC;
                        rem_next     = '0;
                        root_next    = '0;
                        phase_next   = 1'b1;
                    end
                    else
                    begin
                        nb_root_next = sq_root_step;
                        den_next     = '0;
                    end
                end
            end
            ST_DMUL:
            begin
                cnt_next = cnt_reg + cnt_t'(1);
                if (cnt_reg != cnt_t'(0))
                    den_next = den_reg + pp_shift;
                if (cnt_reg == DMUL_LAST)
                    cnt_next = '0;
            end
            ST_DIVCHK:
            begin
                cnt_next = '0;
                if (den_reg == '0)
                    res_next = '0;
                else if (DEN_W'(dot_mag) >= den_reg)
                    res_next = cos_result(ROOT_W'(COS_ONE), dot_neg);
                else
                begin
                    div_r_next = DEN_W'(dot_mag);
                    quo_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next   = cnt_reg + cnt_t'(1);
                div_r_next = dv_r_step;
                quo_next   = dv_q_step;
                if (cnt_reg == ITER_LAST)
                begin
                    cnt_next = '0;
                    res_next = cos_result(dv_q_step, dot_neg);
                end
            end
            ST_DONE:
            begin
                cnt_next = '0;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_reg;
                    out_sat_next   = sat_reg;
                    dot_next       = '0;
                    na_acc_next    = '0;
                    nb_acc_next    = '0;
                    sq_next        = '0;
                    abs_next       = '0;
                    sat_next       = 1'b0;
                end
            end
            default:
                cnt_next = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= MODE_DOT;
            dot_reg       <= '0;
            na_acc_reg    <= '0;
            nb_acc_reg    <= '0;
            sq_reg        <= '0;
            abs_reg       <= '0;
            sat_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
                mode_reg  <= cfg_wr_data;
            dot_reg       <= dot_next;
            na_acc_reg    <= na_acc_next;
            nb_acc_reg    <= nb_acc_next;
            sq_reg        <= sq_next;
            abs_reg       <= abs_next;
            sat_reg       <= sat_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        mag_reg     <= mag_next;
        last_reg    <= last_next;
        prod_reg    <= mul_p;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        na_root_reg <= na_root_next;
        nb_root_reg <= nb_root_next;
        den_reg     <= den_next;
        div_r_reg   <= div_r_next;
        quo_reg     <= quo_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
        out_sat_reg <= out_sat_next;
    end

    //------------------------------------------------------------------
    // Port outputs
    //------------------------------------------------------------------
    always_comb
    begin
        elems.ready         = (state_reg == ST_IDLE);
        result.valid        = out_valid_reg;
        result.metric_value = out_val_reg;
        result.saturated    = out_sat_reg;
    end

endmodule

FILE: design/vsm_checker.sv
module vsm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input vsm_pkg::acc_t metric_value,
    input logic          saturated
);
    import vsm_pkg::*;

    // An accepted pair keeps the block busy for the multiply sequence
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=>
            !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("elems ready returned too early after a word");

    // A fresh result word is only loaded while the input side is busy
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result word appeared while input side idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped before being taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(metric_value) && $stable(saturated)))
        else $error("stalled result word changed");

endmodule

bind vector_similarity_metric_core vsm_checker u_vsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (elems.valid),
    .in_ready     (elems.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .metric_value (result.metric_value),
    .saturated    (result.saturated)
);
